@@ src/apm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the anchored pattern line matcher.
// No dependencies; apm_lookahead, apm_step and the top level import this package.
package apm_pkg;

    typedef logic [7:0] byte_t;

    // Operation codes carried with each input beat
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_LINE = 2'd1,
        OP_EOL  = 2'd2
    } op_t;

    // Character codes used by the pattern syntax
    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_NL    = 8'h0A;
    localparam byte_t CH_OPEN  = 8'h5B;
    localparam byte_t CH_CLOSE = 8'h5D;
    localparam byte_t CH_ESC   = 8'h5C;
    localparam byte_t CH_DASH  = 8'h2D;

    // Pattern bytes visible from the current position: a range element is five long
    localparam int WINDOW_LEN = 5;
    localparam int LEN_W      = 7;
    localparam int ADV_W      = 3;

    typedef byte_t [WINDOW_LEN-1:0] window_t;

    // Outcome of one line byte
    typedef struct packed {
        logic [ADV_W-1:0] advance;
        logic             set_mismatch;
        logic             set_ended;
    } line_step_t;

endpackage

@@ src/apm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module apm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/apm_lookahead.sv @@
`timescale 1ns / 1ps
// Five-byte pattern window: one RAM copy per window slot, write bypass and
// masking of bytes beyond the pattern length. Depends on apm_pkg and apm_ram.
module apm_lookahead #(
    parameter int DEPTH = 64,
    parameter int POS_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [POS_W-1:0]            rd_pos,
    input  logic [apm_pkg::LEN_W-1:0]   pattern_length,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  apm_pkg::byte_t              wr_data,
    output apm_pkg::window_t            window
);
    import apm_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    logic [POS_W-1:0] rd_pos_reg;
    logic             byp_valid_reg;
    logic [AW-1:0]    byp_addr_reg;
    byte_t            byp_data_reg;
    window_t          ram_q;

    // One copy of the store per slot, all written together
    for (genvar j = 0; j < WINDOW_LEN; j++)
    begin : g_slot
        logic [POS_W-1:0] rd_k;

        assign rd_k = rd_pos + POS_W'(j);

        apm_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_k[AW-1:0]),
            .rd_data (ram_q[j])
        );
    end

    // Hold the read address and the last write for the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pos_reg    <= rd_pos;
            byp_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_addr_reg <= wr_addr;
        byp_data_reg <= wr_data;
    end

    // Mask bytes past the pattern or the store, forward a same-cycle write
    always_comb
    begin
        logic [POS_W-1:0] k;
        logic             in_pattern;
        for (int j = 0; j < WINDOW_LEN; j++)
        begin
            k          = rd_pos_reg + POS_W'(j);
            in_pattern = (CMP_W'(k) < CMP_W'(pattern_length)) && (k < POS_W'(DEPTH));
            if (!in_pattern)
            begin
                window[j] = CH_NUL;
            end
            else if (byp_valid_reg && (k[AW-1:0] == byp_addr_reg))
            begin
                window[j] = byp_data_reg;
            end
            else
            begin
                window[j] = ram_q[j];
            end
        end
    end

endmodule

@@ src/apm_step.sv @@
`timescale 1ns / 1ps
// Match step for one line byte against the pattern window.
// Depends on apm_pkg.
module apm_step (
    input  apm_pkg::byte_t     data_byte,
    input  apm_pkg::window_t   window,
    input  logic               mismatch_seen,
    input  logic               content_ended,
    output apm_pkg::line_step_t step
);
    import apm_pkg::*;

    logic end_mark;
    logic is_range;

    assign end_mark = (data_byte == CH_NUL) || (data_byte == CH_NL);
    assign is_range = (window[0] == CH_OPEN) && (window[2] == CH_DASH)
                      && (window[4] == CH_CLOSE);

    // Decide advance or mismatch for one byte
    always_comb
    begin
        step = '0;
        if (content_ended || mismatch_seen || end_mark)
        begin
            step.set_ended = end_mark;
        end
        else if (window[0] == CH_NUL)
        begin
            step.set_mismatch = 1'b1;
        end
        else if (data_byte inside {CH_OPEN, CH_CLOSE, CH_ESC})
        begin
            // Brackets and backslash only match their escape pair
            if ((window[0] == CH_ESC) && (window[1] == data_byte))
            begin
                step.advance = ADV_W'(2);
            end
            else
            begin
                step.set_mismatch = 1'b1;
            end
        end
        else if (data_byte == window[0])
        begin
            step.advance = ADV_W'(1);
        end
        else if (is_range)
        begin
            if ((window[1] <= data_byte) && (data_byte <= window[3]))
            begin
                step.advance = ADV_W'(5);
            end
            else
            begin
                step.set_mismatch = 1'b1;
            end
        end
        else
        begin
            step.set_mismatch = 1'b1;
        end
    end

endmodule

@@ src/anchored_pattern_line_matcher.sv @@
`timescale 1ns / 1ps
// Top level of the anchored pattern line matcher: input register, line state,
// result register. Depends on apm_pkg, apm_lookahead and apm_step.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  item     | item_valid / item_ready     | operation, pattern_index, data_byte
//  result   | result_valid / result_ready | matched, matched_lines
//  config   | cfg_wr_en                   | cfg_wr_data (pattern length)
//
// One beat per cycle sustained unless an end-of-line beat waits; each beat is
// processed from the input register; its end-of-line result follows the cycle after.
// The five-byte window is read from the pattern RAM copies at the next position in
// the cycle before, so a line byte and the position update close in the same cycle.
// Only an end-of-line beat waits on a full result register; other beats never stall.
// Reset clears line state, match count, pattern length and both valid flags;
// the pattern store is not cleared and needs no clearing pass.
module anchored_pattern_line_matcher #(
    parameter int PATTERN_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [apm_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [1:0]                operation,
    input  logic [5:0]                pattern_index,
    input  logic [7:0]                data_byte,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic                      matched,
    output logic [31:0]               matched_lines
);
    import apm_pkg::*;

    localparam int AW    = $clog2(PATTERN_DEPTH);
    localparam int POS_W = $clog2(PATTERN_DEPTH + 9);
    localparam int IW    = (AW + 1 > 6) ? AW + 1 : 6;

    logic [LEN_W-1:0] pattern_length_reg;
    logic             item_valid_reg;
    logic [1:0]       operation_reg;
    logic [5:0]       pattern_index_reg;
    byte_t            data_byte_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             mismatch_reg, mismatch_next;
    logic             ended_reg, ended_next;
    logic [31:0]      count_reg, count_next;
    logic             result_valid_reg;
    logic             matched_reg;
    logic [31:0]      matched_lines_reg;

    op_t              op;
    logic             fire;
    logic             eol_fire;
    logic             line_ok;
    logic             wr_en;
    logic [IW-1:0]    idx_ext;
    window_t          window;
    line_step_t       step;

    assign op       = op_t'(operation_reg);
    assign fire     = item_valid_reg && ((op != OP_EOL) || !result_valid_reg || result_ready);
    assign eol_fire = fire && (op == OP_EOL);
    assign item_ready = !item_valid_reg || fire;

    // Pattern write address; indexes past the store are dropped
    assign idx_ext = IW'(pattern_index_reg);
    assign wr_en   = fire && (op == OP_LOAD) && (idx_ext < IW'(PATTERN_DEPTH));

    apm_lookahead #(
        .DEPTH (PATTERN_DEPTH),
        .POS_W (POS_W)
    ) u_lookahead (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_pos         (pos_next),
        .pattern_length (pattern_length_reg),
        .wr_en          (wr_en),
        .wr_addr        (idx_ext[AW-1:0]),
        .wr_data        (data_byte_reg),
        .window         (window)
    );

    apm_step u_step (
        .data_byte     (data_byte_reg),
        .window        (window),
        .mismatch_seen (mismatch_reg),
        .content_ended (ended_reg),
        .step          (step)
    );

    assign line_ok = !mismatch_reg && (window[0] == CH_NUL);

    // Next line state and match count
    always_comb
    begin
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        ended_next    = ended_reg;
        count_next    = count_reg;
        if (fire)
        begin
            case (op)
                OP_LINE:
                begin
                    pos_next      = pos_reg + POS_W'(step.advance);
                    mismatch_next = mismatch_reg || step.set_mismatch;
                    ended_next    = ended_reg || step.set_ended;
                end
                OP_EOL:
                begin
                    pos_next      = '0;
                    mismatch_next = 1'b0;
                    ended_next    = 1'b0;
                    if (line_ok && (count_reg != '1))
                    begin
                        count_next = count_reg + 32'd1;
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Config register, input beat register, line state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            item_valid_reg     <= 1'b0;
            pos_reg            <= '0;
            mismatch_reg       <= 1'b0;
            ended_reg          <= 1'b0;
            count_reg          <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pattern_length_reg <= cfg_wr_data;
            end
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            pos_reg      <= pos_next;
            mismatch_reg <= mismatch_next;
            ended_reg    <= ended_next;
            count_reg    <= count_next;
            if (eol_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            operation_reg     <= operation;
            pattern_index_reg <= pattern_index;
            data_byte_reg     <= data_byte;
        end
        if (eol_fire)
        begin
            matched_reg       <= line_ok;
            matched_lines_reg <= count_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign matched       = matched_reg;
    assign matched_lines = matched_lines_reg;

    // Position never runs past the last range element beyond the store
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PATTERN_DEPTH + 4))
        else $error("pattern position out of range");

    // End of line clears all line state
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        eol_fire |=> (pos_reg == '0) && !mismatch_reg && !ended_reg)
        else $error("line state not cleared at end of line");

    // The match count never goes down
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("match count decreased");

    // A mismatch stays until end of line
    a_mismatch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mismatch_reg && !eol_fire) |=> mismatch_reg)
        else $error("mismatch dropped within a line");

    // Input stalls only behind a blocked end-of-line beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> item_valid_reg && (op == OP_EOL) && result_valid_reg && !result_ready)
        else $error("input stalled without a blocked result");

endmodule
